FILE: rtl/fihc_pkg.sv
// fihc_pkg: shared types, constants and functions of the firmware image header checker.
// Used by fihc_crc, fihc_hdr and firmware_image_header_checker_core; depends on nothing.
package fihc_pkg;

	localparam int COUNT_BITS = 32;
	localparam int LEN_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
	localparam int HEADER_BYTES = 18;
	localparam int CRC_START = 14;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef logic [COUNT_BITS-1:0] count_t;
	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] CFG_MAJOR = 2'd0;
	localparam logic [1:0] CFG_MINOR = 2'd1;
	localparam logic [1:0] CFG_SUBVER = 2'd2;

	typedef enum logic [2:0] {
		ST_UPGRADE = 3'd0,
		ST_LENGTH = 3'd1,
		ST_MAGIC = 3'd2,
		ST_MAJOR = 3'd3,
		ST_MINOR = 3'd4,
		ST_CRC = 3'd5,
		ST_NOT_NEWER = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] major;
		logic [7:0] minor;
		logic [15:0] subver;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic [15:0] crc;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h41;
			3'd1: b = 8'h70;
			3'd2: b = 8'h70;
			3'd3: b = 8'h42;
			3'd4: b = 8'h69;
			3'd5: b = 8'h6E;
			3'd6: b = 8'h20;
			3'd7: b = 8'h20;
			default: b = 8'h20;
		endcase
		return b;
	endfunction

	// reflected CRC-16, one byte, bitwise
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/fihc_crc.sv
// fihc_crc: next value of the running CRC-16/Modbus for one image byte.
// Depends on fihc_pkg.
module fihc_crc (
	input  logic [15:0] crc_cur,
	input  logic [7:0]  data,
	input  logic        en,
	output logic [15:0] crc_nxt
);

	assign crc_nxt = en ? fihc_pkg::crc_step(crc_cur, data) : crc_cur;

endmodule

FILE: rtl/fihc_hdr.sv
// fihc_hdr: per-image state (byte count, header fields, check flags, CRC) and status.
// Depends on fihc_pkg and fihc_crc.
module fihc_hdr (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	input  logic              last,
	input  fihc_pkg::cfg_t    cfg,
	output fihc_pkg::result_t res
);

	fihc_pkg::count_t cnt_q, cnt_nxt;
	logic [15:0] crc_q, crc_nxt;
	logic [31:0] len_q, len_nxt;
	logic [15:0] scrc_q, scrc_nxt;
	logic [15:0] sub_q, sub_nxt;
	logic magic_bad_q, major_bad_q, minor_bad_q;
	logic magic_bad_nxt, major_bad_nxt, minor_bad_nxt;
	logic [fihc_pkg::LEN_BITS-1:0] len_sum, cnt_ext;
	logic [15:0] crc_out;
	logic len_err;

	fihc_crc u_crc (
		.crc_cur(crc_q),
		.data   (data),
		.en     (cnt_q >= fihc_pkg::count_t'(fihc_pkg::CRC_START)),
		.crc_nxt(crc_nxt)
	);

	always_comb begin
		magic_bad_nxt = magic_bad_q;
		major_bad_nxt = major_bad_q;
		minor_bad_nxt = minor_bad_q;
		sub_nxt = sub_q;
		scrc_nxt = scrc_q;
		len_nxt = len_q;
		if (cnt_q < fihc_pkg::count_t'(8)) begin
			if (data != fihc_pkg::magic_byte(cnt_q[2:0])) begin
				magic_bad_nxt = 1'b1;
			end
		end else if (cnt_q == fihc_pkg::count_t'(8)) begin
			if (data != cfg.major) begin
				major_bad_nxt = 1'b1;
			end
		end else if (cnt_q == fihc_pkg::count_t'(9)) begin
			if (data != cfg.minor) begin
				minor_bad_nxt = 1'b1;
			end
		end else if (cnt_q < fihc_pkg::count_t'(12)) begin
			sub_nxt = {sub_q[7:0], data};
		end else if (cnt_q < fihc_pkg::count_t'(fihc_pkg::CRC_START)) begin
			scrc_nxt = {scrc_q[7:0], data};
		end else if (cnt_q < fihc_pkg::count_t'(fihc_pkg::HEADER_BYTES)) begin
			len_nxt = {len_q[23:0], data};
		end
		cnt_nxt = (cnt_q == fihc_pkg::COUNT_MAX) ? cnt_q : cnt_q + fihc_pkg::count_t'(1);
	end

	always_comb begin
		crc_out = {crc_nxt[7:0], crc_nxt[15:8]};
		len_sum = fihc_pkg::LEN_BITS'(fihc_pkg::HEADER_BYTES) + fihc_pkg::LEN_BITS'(len_nxt);
		cnt_ext = fihc_pkg::LEN_BITS'(cnt_nxt);
		len_err = (cnt_nxt == fihc_pkg::COUNT_MAX) || (cnt_ext != len_sum);
		res.crc = crc_out;
		if (len_err) begin
			res.status = fihc_pkg::ST_LENGTH;
		end else if (magic_bad_nxt) begin
			res.status = fihc_pkg::ST_MAGIC;
		end else if (major_bad_nxt) begin
			res.status = fihc_pkg::ST_MAJOR;
		end else if (minor_bad_nxt) begin
			res.status = fihc_pkg::ST_MINOR;
		end else if (crc_out != scrc_nxt) begin
			res.status = fihc_pkg::ST_CRC;
		end else if (sub_nxt <= cfg.subver) begin
			res.status = fihc_pkg::ST_NOT_NEWER;
		end else begin
			res.status = fihc_pkg::ST_UPGRADE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= fihc_pkg::CRC_INIT;
			len_q <= '0;
			scrc_q <= '0;
			sub_q <= '0;
			magic_bad_q <= 1'b0;
			major_bad_q <= 1'b0;
			minor_bad_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				cnt_q <= '0;
				crc_q <= fihc_pkg::CRC_INIT;
				len_q <= '0;
				scrc_q <= '0;
				sub_q <= '0;
				magic_bad_q <= 1'b0;
				major_bad_q <= 1'b0;
				minor_bad_q <= 1'b0;
			end else begin
				cnt_q <= cnt_nxt;
				crc_q <= crc_nxt;
				len_q <= len_nxt;
				scrc_q <= scrc_nxt;
				sub_q <= sub_nxt;
				magic_bad_q <= magic_bad_nxt;
				major_bad_q <= major_bad_nxt;
				minor_bad_q <= minor_bad_nxt;
			end
		end
	end

endmodule

FILE: rtl/firmware_image_header_checker_core.sv
// firmware_image_header_checker_core: top level; input register, config registers,
// result register. Depends on fihc_pkg and fihc_hdr.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata = data_byte, s_tlast = last_byte
//  m_*     | out | m_tvalid/m_tready | m_tdata = status, computed_crc
//  cfg_*   | in  | cfg_we            | cfg_index, cfg_data
//
// One byte per cycle unless a last byte waits on a stalled result; each byte is held
// in the input register and folded into the image state as it leaves it. An image's
// status goes into the output register as its last byte leaves the input register.
// Reset clears the image state and the config registers (CRC to 0xFFFF).
// A stalled result holds back a last byte and those after it; other bytes still flow.
module firmware_image_header_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] status, [18:3] computed_crc, [23:19] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic valid_s1, last_s1;
	logic [7:0] data_s1;
	logic valid_s2;
	fihc_pkg::result_t res_s2;
	fihc_pkg::result_t res;
	fihc_pkg::cfg_t cfg_q;
	logic out_free, step;

	assign out_free = !valid_s2 || m_tready;
	assign step = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fihc_pkg::CFG_MAJOR: cfg_q.major <= cfg_data[7:0];
				fihc_pkg::CFG_MINOR: cfg_q.minor <= cfg_data[7:0];
				fihc_pkg::CFG_SUBVER: cfg_q.subver <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	fihc_hdr u_hdr (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.data  (data_s1),
		.last  (last_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {5'd0, res_s2.crc, res_s2.status};

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> m_tvalid)
		else $error("last byte did not produce a result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("input register changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("undefined status code");

endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for firmware_image_header_checker_core.
// Streams whole and broken images through s_*, predicts each status and CRC, checks m_*.
// Depends on rtl/fihc_pkg.sv and rtl/firmware_image_header_checker_core.sv.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] MAGIC [8] = '{8'h41, 8'h70, 8'h70, 8'h42, 8'h69, 8'h6E, 8'h20, 8'h20};

	// image flaw mask bits
	localparam int FL_LENGTH = 0;
	localparam int FL_MAGIC = 1;
	localparam int FL_MAJOR = 2;
	localparam int FL_MINOR = 3;
	localparam int FL_CRC = 4;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = fihc_pkg::CFG_MAJOR;
	logic [15:0] cfg_data = 16'h0000;

	firmware_image_header_checker_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// configuration shadow
	logic [7:0]  cfg_major = 8'h00;
	logic [7:0]  cfg_minor = 8'h00;
	logic [15:0] cfg_subver = 16'h0000;

	// per-image prediction state
	fihc_pkg::count_t run_count = '0;
	logic [15:0] run_crc = 16'hFFFF;
	logic [31:0] decl_len = '0;
	logic [15:0] hdr_crc = '0;
	logic [15:0] hdr_subver = '0;
	logic        magic_bad = 1'b0;
	logic        major_bad = 1'b0;
	logic        minor_bad = 1'b0;

	fihc_pkg::result_t pending_verdicts[$];
	logic [7:0]  image_bytes[$];
	int          snk_pct = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          images_sent = 0;
	int          bytes_sent = 0;
	int          status_hits[7] = '{default: 0};

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_verdicts.size());
		$display("tb NOT OK");
		$finish;
	end

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	task automatic fold_byte(input logic [7:0] b, input logic last);
		fihc_pkg::count_t pos;
		logic [15:0] crc_tx;
		fihc_pkg::status_t st;
		pos = run_count;
		if (pos < 8) begin
			if (b != MAGIC[pos[2:0]]) begin
				magic_bad = 1'b1;
			end
		end else if (pos == 8) begin
			if (b != cfg_major) begin
				major_bad = 1'b1;
			end
		end else if (pos == 9) begin
			if (b != cfg_minor) begin
				minor_bad = 1'b1;
			end
		end else if (pos < 12) begin
			hdr_subver = {hdr_subver[7:0], b};
		end else if (pos < 14) begin
			hdr_crc = {hdr_crc[7:0], b};
		end else if (pos < 18) begin
			decl_len = {decl_len[23:0], b};
		end
		if (pos >= 14) begin
			run_crc = crc_fold(run_crc, b);
		end
		if (run_count != fihc_pkg::COUNT_MAX) begin
			run_count = run_count + 1'b1;
		end
		if (last) begin
			crc_tx = {run_crc[7:0], run_crc[15:8]};
			if (run_count == fihc_pkg::COUNT_MAX ||
					64'(run_count) != 64'd18 + 64'(decl_len)) begin
				st = fihc_pkg::ST_LENGTH;
			end else if (magic_bad) begin
				st = fihc_pkg::ST_MAGIC;
			end else if (major_bad) begin
				st = fihc_pkg::ST_MAJOR;
			end else if (minor_bad) begin
				st = fihc_pkg::ST_MINOR;
			end else if (crc_tx != hdr_crc) begin
				st = fihc_pkg::ST_CRC;
			end else if (hdr_subver <= cfg_subver) begin
				st = fihc_pkg::ST_NOT_NEWER;
			end else begin
				st = fihc_pkg::ST_UPGRADE;
			end
			pending_verdicts.push_back('{status: st, crc: crc_tx});
			run_count = '0;
			run_crc = 16'hFFFF;
			decl_len = '0;
			hdr_crc = '0;
			hdr_subver = '0;
			magic_bad = 1'b0;
			major_bad = 1'b0;
			minor_bad = 1'b0;
		end
	endtask

	task automatic log_mismatch(input string what, input logic [23:0] exp_v,
			input logic [23:0] act_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		fihc_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				log_mismatch("unexpected transaction", 24'h0, m_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				status_hits[want.status]++;
				if (m_tdata[2:0] != want.status) begin
					log_mismatch("status", 24'(want.status), 24'(m_tdata[2:0]));
				end
				if (m_tdata[18:3] != want.crc) begin
					log_mismatch("computed_crc", 24'(want.crc), 24'(m_tdata[18:3]));
				end
				if (m_tdata[23:19] != 5'd0) begin
					log_mismatch("pad bits", 24'h0, 24'(m_tdata[23:19]));
				end
			end
		end
		m_tready <= (snk_pct == 0) || ($urandom_range(99) >= snk_pct);
	end

	task automatic push_byte(input logic [7:0] b, input logic last, input int idle_pct);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		fold_byte(b, last);
	endtask

	task automatic send_image(input int idle_pct);
		int pct;
		pct = ($urandom_range(4) == 0) ? 0 : idle_pct;
		for (int i = 0; i < image_bytes.size(); i++) begin
			push_byte(image_bytes[i], i == image_bytes.size() - 1, pct);
		end
		images_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fihc_pkg::CFG_MAJOR: cfg_major = val[7:0];
			fihc_pkg::CFG_MINOR: cfg_minor = val[7:0];
			fihc_pkg::CFG_SUBVER: cfg_subver = val;
			default: ;
		endcase
	endtask

	task automatic build_image(input logic [4:0] flaws, input logic [15:0] subver,
			input int plen);
		logic [31:0] decl;
		logic [15:0] c;
		int          pick;
		image_bytes.delete();
		for (int i = 0; i < 8; i++) begin
			image_bytes.push_back(MAGIC[i]);
		end
		if (flaws[FL_MAGIC]) begin
			pick = $urandom_range(7);
			image_bytes[pick] = image_bytes[pick] ^ 8'($urandom_range(1, 255));
		end
		image_bytes.push_back(flaws[FL_MAJOR] ? cfg_major ^ 8'($urandom_range(1, 255))
				: cfg_major);
		image_bytes.push_back(flaws[FL_MINOR] ? cfg_minor ^ 8'($urandom_range(1, 255))
				: cfg_minor);
		image_bytes.push_back(subver[15:8]);
		image_bytes.push_back(subver[7:0]);
		image_bytes.push_back(8'h00);
		image_bytes.push_back(8'h00);
		decl = plen;
		if (flaws[FL_LENGTH]) begin
			decl = decl ^ (32'd1 << $urandom_range(31));
		end
		for (int i = 3; i >= 0; i--) begin
			image_bytes.push_back(decl[8*i +: 8]);
		end
		for (int i = 0; i < plen; i++) begin
			image_bytes.push_back(8'($urandom));
		end
		c = 16'hFFFF;
		for (int i = 14; i < image_bytes.size(); i++) begin
			c = crc_fold(c, image_bytes[i]);
		end
		// stored CRC goes out low register byte first
		image_bytes[12] = c[7:0];
		image_bytes[13] = c[15:8];
		if (flaws[FL_CRC]) begin
			pick = 12 + $urandom_range(1);
			image_bytes[pick] = image_bytes[pick] ^ 8'($urandom_range(1, 255));
		end
	endtask

	task automatic test_reset_config();
		build_image(5'b0, 16'h0001, 0);
		send_image(0);
		build_image(5'b0, 16'h0000, 3);
		send_image(0);
	endtask

	task automatic test_status_priority();
		write_reg(fihc_pkg::CFG_MAJOR, 16'h00A5);
		write_reg(fihc_pkg::CFG_MINOR, 16'h003C);
		write_reg(fihc_pkg::CFG_SUBVER, 16'h1234);
		build_image(5'b0, 16'h1235, 5);
		send_image(0);
		build_image(5'b0, 16'h1234, 2);
		send_image(0);
		build_image(5'b1 << FL_LENGTH, 16'h1235, 1);
		send_image(0);
		build_image(5'b1 << FL_MAGIC, 16'h1235, 0);
		send_image(0);
		build_image(5'b1 << FL_MAJOR, 16'h1235, 4);
		send_image(0);
		build_image(5'b1 << FL_MINOR, 16'h1235, 0);
		send_image(0);
		build_image(5'b1 << FL_CRC, 16'h1235, 7);
		send_image(0);
		build_image(5'b11111, 16'h0000, 2);
		send_image(0);
		build_image(5'b11110, 16'hFFFF, 0);
		send_image(0);
		write_reg(fihc_pkg::CFG_MAJOR, 16'h00FF);
		write_reg(fihc_pkg::CFG_MINOR, 16'h00FF);
		write_reg(fihc_pkg::CFG_SUBVER, 16'hFFFF);
		build_image(5'b0, 16'hFFFF, 1);
		send_image(0);
	endtask

	task automatic test_short_images();
		int cut;
		image_bytes.delete();
		image_bytes.push_back(8'hFF);
		send_image(0);
		image_bytes.delete();
		foreach (MAGIC[i]) begin
			image_bytes.push_back(MAGIC[i]);
		end
		send_image(0);
		cut = 0;
		build_image(5'b0, 16'h0001, 0);
		while (image_bytes.size() > 14) begin
			void'(image_bytes.pop_back());
		end
		send_image(0);
		build_image(5'b0, 16'h0001, 0);
		void'(image_bytes.pop_back());
		send_image(cut);
	endtask

	task automatic test_random_phase(input int src_pct, input int sink_pct, input int nbytes);
		int start_bytes;
		int start_images;
		int r;
		int plen;
		logic [15:0] sv;
		logic [4:0]  flaws;
		snk_pct = sink_pct;
		start_bytes = bytes_sent;
		start_images = images_sent;
		while (bytes_sent - start_bytes < nbytes || images_sent - start_images < 6) begin
			r = $urandom_range(99);
			case ($urandom_range(4))
				0: sv = cfg_subver;
				1: sv = cfg_subver + 1'b1;
				2: sv = 16'h0000;
				3: sv = 16'hFFFF;
				default: sv = 16'($urandom);
			endcase
			plen = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			if (r < 10) begin
				image_bytes.delete();
				repeat ($urandom_range(1, 40)) image_bytes.push_back(8'($urandom));
			end else if (r < 18) begin
				build_image(5'b0, sv, plen);
				repeat ($urandom_range(1, image_bytes.size() - 1)) void'(image_bytes.pop_back());
			end else begin
				for (int i = 0; i < 5; i++) begin
					flaws[i] = ($urandom_range(99) < 12);
				end
				build_image(flaws, sv, plen);
			end
			send_image(src_pct);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_status_priority();
		test_short_images();
		write_reg(fihc_pkg::CFG_MAJOR, 16'h00FF);
		write_reg(fihc_pkg::CFG_MINOR, 16'h0000);
		write_reg(fihc_pkg::CFG_SUBVER, 16'($urandom));
		test_random_phase(8, 63, 160);
		write_reg(fihc_pkg::CFG_MAJOR, 16'h0000);
		write_reg(fihc_pkg::CFG_MINOR, 16'h00FF);
		write_reg(fihc_pkg::CFG_SUBVER, 16'hFFFF);
		test_random_phase(63, 8, 160);
		write_reg(fihc_pkg::CFG_MAJOR, 16'($urandom_range(255)));
		write_reg(fihc_pkg::CFG_MINOR, 16'($urandom_range(255)));
		write_reg(fihc_pkg::CFG_SUBVER, 16'h0000);
		test_random_phase(0, 0, 160);
		drain_results();
		$display("%0d images, %0d bytes sent; %0d results checked, %0d mismatches",
				images_sent, bytes_sent, results_seen, mismatches);
		$display("status counts upgrade..not_newer: %0d %0d %0d %0d %0d %0d %0d",
				status_hits[0], status_hits[1], status_hits[2], status_hits[3],
				status_hits[4], status_hits[5], status_hits[6]);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
